@@ hw/rtl/brli_pkg.sv @@
`timescale 1ns / 1ps

package brli_pkg;

    // Build-time defaults
    localparam int MAX_ENTRIES_DEF       = 32;
    localparam int BLOCK_SHIFT_DEF       = 12;
    localparam int BLOCK_NUMBER_BITS_DEF = 20;

    // Fixed field widths
    localparam int ADDR_W   = 32;
    localparam int CFG_W    = 32;
    localparam int CAP_W    = 6;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 5;
    localparam int OUT_BLK_W = 20;
    localparam int CFG_IDX_W = 2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_HIT    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_APPEND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_COPY   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DONE   = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DISK_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISK_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOG_CAP   = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] DISK_BASE_RST = 32'h1000_0000;
    localparam logic [CFG_W-1:0] DISK_SIZE_RST = 32'hC000_0000;
    localparam logic [CAP_W-1:0] LOG_CAP_RST   = 6'd32;

    // Operation codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_COMMIT = 1'b1;

    typedef struct packed {
        logic                capture;     // latch input transaction
        logic                check;       // latch block number, restart scan
        logic                scan;        // one step of the slot search
        logic                rd_first;    // read slot 0 for commit
        logic                rd_next;     // read next slot for commit
        logic                append;      // write block into next free slot
        logic                clear_count; // empty the log
        logic                load;        // load the output register
        logic [STATUS_W-1:0] kind;        // status of the loaded result
    } brli_cmd_t;

    typedef struct packed {
        logic op;        // captured operation
        logic in_range;  // captured address lies in the disk window
        logic hit;       // search found the block
        logic miss;      // search exhausted without a match
        logic full;      // no usable slot left
        logic empty;     // log holds no entries
        logic more;      // commit has another slot after the current one
        logic can_load;  // output register free or draining this cycle
    } brli_status_t;

endpackage

@@ hw/rtl/brli_ctrl.sv @@
`timescale 1ns / 1ps

module brli_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  brli_pkg::brli_status_t st,
    output brli_pkg::brli_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SEARCH   = 3'd2;
    localparam logic [2:0] S_O_HIT    = 3'd3;
    localparam logic [2:0] S_O_MISS   = 3'd4;
    localparam logic [2:0] S_O_RANGE  = 3'd5;
    localparam logic [2:0] S_C_COPY   = 3'd6;
    localparam logic [2:0] S_C_DONE   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (st.op == brli_pkg::OP_COMMIT) begin
                    if (st.empty) begin
                        state_next = S_C_DONE;
                    end else begin
                        cmd.rd_first = 1'b1;
                        state_next   = S_C_COPY;
                    end
                end else begin
                    cmd.check  = 1'b1;
                    state_next = st.in_range ? S_SEARCH : S_O_RANGE;
                end
            end
            S_SEARCH: begin
                cmd.scan = 1'b1;
                if (st.hit) begin
                    state_next = S_O_HIT;
                end else if (st.miss) begin
                    state_next = S_O_MISS;
                end
            end
            S_O_HIT: begin
                if (st.can_load) begin
                    cmd.load   = 1'b1;
                    cmd.kind   = brli_pkg::ST_HIT;
                    state_next = S_IDLE;
                end
            end
            S_O_MISS: begin
                if (st.can_load) begin
                    cmd.load   = 1'b1;
                    cmd.kind   = st.full ? brli_pkg::ST_FULL : brli_pkg::ST_APPEND;
                    cmd.append = !st.full;
                    state_next = S_IDLE;
                end
            end
            S_O_RANGE: begin
                if (st.can_load) begin
                    cmd.load   = 1'b1;
                    cmd.kind   = brli_pkg::ST_RANGE;
                    state_next = S_IDLE;
                end
            end
            S_C_COPY: begin
                if (st.can_load) begin
                    cmd.load = 1'b1;
                    cmd.kind = brli_pkg::ST_COPY;
                    if (st.more) begin
                        cmd.rd_next = 1'b1;
                    end else begin
                        state_next = S_C_DONE;
                    end
                end
            end
            S_C_DONE: begin
                if (st.can_load) begin
                    cmd.load        = 1'b1;
                    cmd.kind        = brli_pkg::ST_DONE;
                    cmd.clear_count = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/brli_dp.sv @@
`timescale 1ns / 1ps

module brli_dp #(
    parameter int MAX_ENTRIES       = brli_pkg::MAX_ENTRIES_DEF,
    parameter int BLOCK_SHIFT       = brli_pkg::BLOCK_SHIFT_DEF,
    parameter int BLOCK_NUMBER_BITS = brli_pkg::BLOCK_NUMBER_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [brli_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [brli_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                              s_operation,
    input  logic [brli_pkg::ADDR_W-1:0]       s_write_address,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [brli_pkg::STATUS_W-1:0]     m_status,
    output logic [brli_pkg::SLOT_W-1:0]       m_slot_index,
    output logic [brli_pkg::OUT_BLK_W-1:0]    m_block_number,
    output logic                              m_last,
    input  brli_pkg::brli_cmd_t               cmd,
    output brli_pkg::brli_status_t            st
);

    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int BNB = BLOCK_NUMBER_BITS;
    localparam logic [brli_pkg::CAP_W:0] MAX_CAP = (brli_pkg::CAP_W + 1)'(MAX_ENTRIES);

    // Configuration registers
    logic [brli_pkg::CFG_W-1:0] disk_base_reg;
    logic [brli_pkg::CFG_W-1:0] disk_size_reg;
    logic [brli_pkg::CAP_W-1:0] log_cap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disk_base_reg <= brli_pkg::DISK_BASE_RST;
            disk_size_reg <= brli_pkg::DISK_SIZE_RST;
            log_cap_reg   <= brli_pkg::LOG_CAP_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                brli_pkg::REG_DISK_BASE: disk_base_reg <= cfg_wdata;
                brli_pkg::REG_DISK_SIZE: disk_size_reg <= cfg_wdata;
                brli_pkg::REG_LOG_CAP:   log_cap_reg   <= cfg_wdata[brli_pkg::CAP_W-1:0];
                default: ;
            endcase
        end
    end

    // Captured transaction
    logic                        op_reg;
    logic [brli_pkg::ADDR_W-1:0] addr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= s_operation;
            addr_reg <= s_write_address;
        end
    end

    // Window test: addr - base < size once addr >= base, so the end never wraps
    logic [brli_pkg::ADDR_W-1:0] diff;
    logic [brli_pkg::ADDR_W-1:0] shifted;
    logic                        in_range;

    assign diff     = addr_reg - disk_base_reg;
    assign shifted  = diff >> BLOCK_SHIFT;
    assign in_range = (addr_reg >= disk_base_reg) && (diff < disk_size_reg);

    logic [BNB-1:0] block_reg;

    // Log store
    logic [BNB-1:0] mem [MAX_ENTRIES];
    logic [BNB-1:0] rd_data_reg;
    logic [CW-1:0]  rd_idx_reg;
    logic           rd_valid_reg;
    logic [CW-1:0]  scan_idx_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  idx_inc;
    logic [CW-1:0]  rd_addr_full;
    logic           issue;
    logic           scan_rd;
    logic           rd_en;
    logic           hit;

    assign idx_inc = scan_idx_reg + 1'b1;
    assign issue   = scan_idx_reg < count_reg;
    assign hit     = rd_valid_reg && (rd_data_reg == block_reg);
    assign scan_rd = cmd.scan && issue && !hit;
    assign rd_en   = scan_rd || cmd.rd_first || cmd.rd_next;

    always_comb begin
        if (cmd.rd_first) begin
            rd_addr_full = '0;
        end else if (cmd.rd_next) begin
            rd_addr_full = idx_inc;
        end else begin
            rd_addr_full = scan_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.append) begin
            mem[count_reg[AW-1:0]] <= block_reg;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr_full[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.check) begin
            block_reg <= shifted[BNB-1:0];
        end
        if (scan_rd) begin
            rd_idx_reg <= scan_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg <= '0;
            rd_valid_reg <= 1'b0;
            count_reg    <= '0;
        end else begin
            if (cmd.check || cmd.rd_first) begin
                scan_idx_reg <= '0;
            end else if (scan_rd || cmd.rd_next) begin
                scan_idx_reg <= idx_inc;
            end
            if (cmd.check) begin
                rd_valid_reg <= 1'b0;
            end else if (cmd.scan) begin
                rd_valid_reg <= scan_rd;
            end
            if (cmd.clear_count) begin
                count_reg <= '0;
            end else if (cmd.append) begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Capacity clipped to the built depth
    logic [brli_pkg::CAP_W:0] cap_ext;
    logic [brli_pkg::CAP_W:0] cap_eff;
    logic [CW:0]              idx_inc_ext;

    assign cap_ext     = {1'b0, log_cap_reg};
    assign cap_eff     = (cap_ext > MAX_CAP) ? MAX_CAP : cap_ext;
    assign idx_inc_ext = {1'b0, scan_idx_reg} + 1'b1;

    // Output register
    logic                            m_valid_reg;
    logic [brli_pkg::STATUS_W-1:0]   m_status_reg;
    logic [brli_pkg::SLOT_W-1:0]     m_slot_reg;
    logic [brli_pkg::OUT_BLK_W-1:0]  m_block_reg;
    logic                            m_last_reg;
    logic [brli_pkg::SLOT_W-1:0]     slot_sel;
    logic [brli_pkg::OUT_BLK_W-1:0]  block_sel;
    logic                            last_sel;

    always_comb begin
        slot_sel  = '0;
        block_sel = '0;
        last_sel  = 1'b1;
        unique case (cmd.kind)
            brli_pkg::ST_HIT: begin
                slot_sel  = brli_pkg::SLOT_W'(rd_idx_reg);
                block_sel = brli_pkg::OUT_BLK_W'(block_reg);
            end
            brli_pkg::ST_APPEND: begin
                slot_sel  = brli_pkg::SLOT_W'(count_reg);
                block_sel = brli_pkg::OUT_BLK_W'(block_reg);
            end
            brli_pkg::ST_FULL: begin
                block_sel = brli_pkg::OUT_BLK_W'(block_reg);
            end
            brli_pkg::ST_COPY: begin
                slot_sel  = brli_pkg::SLOT_W'(scan_idx_reg);
                block_sel = brli_pkg::OUT_BLK_W'(rd_data_reg);
                last_sel  = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_status_reg <= cmd.kind;
            m_slot_reg   <= slot_sel;
            m_block_reg  <= block_sel;
            m_last_reg   <= last_sel;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_slot_index   = m_slot_reg;
    assign m_block_number = m_block_reg;
    assign m_last         = m_last_reg;

    always_comb begin
        st.op       = op_reg;
        st.in_range = in_range;
        st.hit      = hit;
        st.miss     = !rd_valid_reg && !issue;
        st.full     = (brli_pkg::CAP_W + 1)'(count_reg) >= cap_eff;
        st.empty    = (count_reg == '0);
        st.more     = idx_inc_ext < {1'b0, count_reg};
        st.can_load = !m_valid_reg || m_ready;
    end

endmodule

@@ hw/rtl/block_redo_log_index_core.sv @@
`timescale 1ns / 1ps

// Redo log index engine.
// Input channel (s_*): one transaction per item. A write item (operation 0)
// carries a byte address; the engine range-checks it against the disk window,
// derives the block number and searches the logged slots one per cycle.
// It returns one result: hit, appended, out of range or log full.
// A commit item (operation 1) returns one copy result per logged slot, in slot
// order, then a done result with m_last set, and empties the log.
// Result channel (m_*): registered output; a new item is taken while the last
// result still waits. With a result waiting and m_ready low, the engine stalls.
// An out-of-range item goes from dispatch straight to its result. Any other
// write item scans the logged slots through the single read port of the log
// store until it finds a hit or runs past the last slot. A commit shows its
// copy results one per cycle while m_ready stays high, then the done result.
// The next item is taken the cycle after its result is loaded, so the input
// stays closed while an item is still in flight.
// Configuration (cfg_*) writes take effect at once; write only while idle.
// Reset (aresetn low, synchronous) restores the register defaults and empties
// the log; no clearing pass is needed.
module block_redo_log_index_core #(
    parameter int MAX_ENTRIES       = brli_pkg::MAX_ENTRIES_DEF,
    parameter int BLOCK_SHIFT       = brli_pkg::BLOCK_SHIFT_DEF,
    parameter int BLOCK_NUMBER_BITS = brli_pkg::BLOCK_NUMBER_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [brli_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [brli_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_operation,
    input  logic [brli_pkg::ADDR_W-1:0]       s_write_address,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [brli_pkg::STATUS_W-1:0]     m_status,
    output logic [brli_pkg::SLOT_W-1:0]       m_slot_index,
    output logic [brli_pkg::OUT_BLK_W-1:0]    m_block_number,
    output logic                              m_last
);

    brli_pkg::brli_cmd_t    cmd;
    brli_pkg::brli_status_t st;

    brli_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    brli_dp #(
        .MAX_ENTRIES       (MAX_ENTRIES),
        .BLOCK_SHIFT       (BLOCK_SHIFT),
        .BLOCK_NUMBER_BITS (BLOCK_NUMBER_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_operation     (s_operation),
        .s_write_address (s_write_address),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_slot_index    (m_slot_index),
        .m_block_number  (m_block_number),
        .m_last          (m_last),
        .cmd             (cmd),
        .st              (st)
    );

endmodule

@@ hw/rtl/brli_checker.sv @@
`timescale 1ns / 1ps

module brli_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [brli_pkg::STATUS_W-1:0]     m_status,
    input logic [brli_pkg::SLOT_W-1:0]       m_slot_index,
    input logic [brli_pkg::OUT_BLK_W-1:0]    m_block_number,
    input logic                              m_last
);

    // Stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_slot_index)
            && $stable(m_block_number) && $stable(m_last))
        else $error("result changed while stalled");

    // Only copy results leave the item open
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_status != brli_pkg::ST_COPY)))
        else $error("last flag does not match status");

    // Out of range and done results carry no slot or block
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == brli_pkg::ST_RANGE || m_status == brli_pkg::ST_DONE)
            |-> m_slot_index == '0 && m_block_number == '0)
        else $error("nonzero payload on range or done result");

    // A log full result never names a slot
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == brli_pkg::ST_FULL |-> m_slot_index == '0)
        else $error("slot on log full result");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind block_redo_log_index_core brli_checker u_brli_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_slot_index   (m_slot_index),
    .m_block_number (m_block_number),
    .m_last         (m_last)
);

@@ dv/tb_block_redo_log_index_core.sv @@
`timescale 1ns / 1ps

module tb_block_redo_log_index_core;

    localparam int IDLE_LIMIT  = 4000;
    localparam int LATENCY_PAD = 40;
    localparam int PHASE_ITEMS = 18;

    typedef struct packed {
        logic [brli_pkg::STATUS_W-1:0]  status;
        logic [brli_pkg::SLOT_W-1:0]    slot;
        logic [brli_pkg::OUT_BLK_W-1:0] blk;
        logic                           last;
    } log_result_t;

    typedef struct packed {
        logic                           is_cfg;
        logic                           op;
        logic [brli_pkg::CFG_IDX_W-1:0] idx;
        logic [brli_pkg::CFG_W-1:0]     value;  // write address, or register data
        logic                           typed;
        log_result_t                    want;
    } plan_row_t;

    logic                           aclk;
    logic                           aresetn         = 1'b0;
    logic                           cfg_wr_en       = 1'b0;
    logic [brli_pkg::CFG_IDX_W-1:0] cfg_index       = '0;
    logic [brli_pkg::CFG_W-1:0]     cfg_wdata       = '0;
    logic                           s_valid         = 1'b0;
    logic                           s_ready;
    logic                           s_operation     = brli_pkg::OP_WRITE;
    logic [brli_pkg::ADDR_W-1:0]    s_write_address = '0;
    logic                           m_valid;
    logic                           m_ready         = 1'b0;
    logic [brli_pkg::STATUS_W-1:0]  m_status;
    logic [brli_pkg::SLOT_W-1:0]    m_slot_index;
    logic [brli_pkg::OUT_BLK_W-1:0] m_block_number;
    logic                           m_last;

    block_redo_log_index_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_write_address (s_write_address),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_slot_index    (m_slot_index),
        .m_block_number  (m_block_number),
        .m_last          (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Shadow copy of the log index
    logic [brli_pkg::CFG_W-1:0]                 cfg_base = brli_pkg::DISK_BASE_RST;
    logic [brli_pkg::CFG_W-1:0]                 cfg_size = brli_pkg::DISK_SIZE_RST;
    logic [brli_pkg::CAP_W-1:0]                 cfg_cap  = brli_pkg::LOG_CAP_RST;
    logic [brli_pkg::BLOCK_NUMBER_BITS_DEF-1:0] blk_log [brli_pkg::MAX_ENTRIES_DEF];
    int                                         used_slots = 0;

    log_result_t fresh_results[$];
    log_result_t log_results_due[$];
    plan_row_t   plan[$];
    int          fail_count = 0;
    bit          tx_quiet   = 1'b0;

    function automatic log_result_t mk(input logic [brli_pkg::STATUS_W-1:0] st,
                                       input int slot,
                                       input logic [brli_pkg::OUT_BLK_W-1:0] blk,
                                       input logic last);
        log_result_t r;
        r.status = st;
        r.slot   = brli_pkg::SLOT_W'(slot);
        r.blk    = blk;
        r.last   = last;
        return r;
    endfunction

    // Fills fresh_results with what one input transaction produces and updates the log.
    function automatic void forecast_log_op(input logic op,
                                            input logic [brli_pkg::ADDR_W-1:0] addr);
        logic [brli_pkg::ADDR_W:0]                  win_end;
        logic [brli_pkg::ADDR_W-1:0]                offset;
        logic [brli_pkg::BLOCK_NUMBER_BITS_DEF-1:0] blk;
        int                                         eff_cap;
        int                                         i;
        int                                         found;
        fresh_results.delete();
        if (op == brli_pkg::OP_COMMIT) begin
            for (i = 0; i < used_slots; i++)
                fresh_results.push_back(mk(brli_pkg::ST_COPY, i, blk_log[i], 1'b0));
            fresh_results.push_back(mk(brli_pkg::ST_DONE, 0, '0, 1'b1));
            used_slots = 0;
            return;
        end
        // window end kept at 33 bits so it never wraps
        win_end = {1'b0, cfg_base} + {1'b0, cfg_size};
        if (addr < cfg_base || {1'b0, addr} >= win_end) begin
            fresh_results.push_back(mk(brli_pkg::ST_RANGE, 0, '0, 1'b1));
            return;
        end
        offset = addr - cfg_base;
        blk    = brli_pkg::BLOCK_NUMBER_BITS_DEF'(offset >> brli_pkg::BLOCK_SHIFT_DEF);
        found  = -1;
        i      = 0;
        while (i < used_slots && found < 0) begin
            if (blk_log[i] == blk)
                found = i;
            i++;
        end
        if (found >= 0) begin
            fresh_results.push_back(mk(brli_pkg::ST_HIT, found, blk, 1'b1));
            return;
        end
        eff_cap = (cfg_cap > brli_pkg::MAX_ENTRIES_DEF) ? brli_pkg::MAX_ENTRIES_DEF
                                                        : int'(cfg_cap);
        if (used_slots >= eff_cap) begin
            fresh_results.push_back(mk(brli_pkg::ST_FULL, 0, blk, 1'b1));
            return;
        end
        blk_log[used_slots] = blk;
        fresh_results.push_back(mk(brli_pkg::ST_APPEND, used_slots, blk, 1'b1));
        used_slots++;
    endfunction

    task automatic row_item(input logic op, input logic [brli_pkg::ADDR_W-1:0] addr);
        plan_row_t r;
        r        = '0;
        r.op     = op;
        r.value  = addr;
        plan.push_back(r);
    endtask

    task automatic row_chk(input logic op, input logic [brli_pkg::ADDR_W-1:0] addr,
                           input logic [brli_pkg::STATUS_W-1:0] st, input int slot,
                           input logic [brli_pkg::OUT_BLK_W-1:0] blk);
        plan_row_t r;
        r        = '0;
        r.op     = op;
        r.value  = addr;
        r.typed  = 1'b1;
        r.want   = mk(st, slot, blk, 1'b1);
        plan.push_back(r);
    endtask

    task automatic row_cfg(input logic [brli_pkg::CFG_IDX_W-1:0] idx,
                           input logic [brli_pkg::CFG_W-1:0] val);
        plan_row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.value  = val;
        plan.push_back(r);
    endtask

    task automatic send_item(input logic op, input logic [brli_pkg::ADDR_W-1:0] addr,
                             input logic typed, input log_result_t want);
        int gap;
        if ($urandom_range(0, 15) == 0)
            tx_quiet = !tx_quiet;
        gap = tx_quiet ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_operation     <= op;
        s_write_address <= addr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        forecast_log_op(op, addr);
        if (typed)
            log_results_due.push_back(want);
        else
            foreach (fresh_results[k]) log_results_due.push_back(fresh_results[k]);
    endtask

    // Stop sending and wait until every expected result is back, then a pad.
    task automatic drain(input int pad);
        s_valid <= 1'b0;
        do @(posedge aclk); while (log_results_due.size() != 0);
        repeat (pad) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [brli_pkg::CFG_IDX_W-1:0] idx,
                             input logic [brli_pkg::CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            brli_pkg::REG_DISK_BASE: cfg_base = val;
            brli_pkg::REG_DISK_SIZE: cfg_size = val;
            brli_pkg::REG_LOG_CAP:   cfg_cap  = val[brli_pkg::CAP_W-1:0];
            default: ;
        endcase
    endtask

    // Result side: check each transaction, then draw the stall before the next one.
    int rx_wait  = 0;
    bit rx_quiet = 1'b0;

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : result_side
        log_result_t want;
        int          draw;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else if (m_valid && m_ready) begin
            if (log_results_due.size() == 0) begin
                $error("unexpected result: status %0d slot %0d block 0x%0h last %0b",
                       m_status, m_slot_index, m_block_number, m_last);
                fail_count++;
            end else begin
                want = log_results_due.pop_front();
                check_field("status", 32'(want.status), 32'(m_status));
                check_field("slot_index", 32'(want.slot), 32'(m_slot_index));
                check_field("block_number", 32'(want.blk), 32'(m_block_number));
                check_field("last", 32'(want.last), 32'(m_last));
            end
            if ($urandom_range(0, 15) == 0)
                rx_quiet = !rx_quiet;
            draw = rx_quiet ? 0 : $urandom_range(0, 11);
            rx_wait <= draw;
            m_ready <= (draw == 0);
        end else if (rx_wait != 0) begin
            rx_wait <= rx_wait - 1;
            m_ready <= (rx_wait == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: cycles with no transaction on either channel
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic                        cfg_open;
        logic                        op;
        logic [brli_pkg::ADDR_W-1:0] addr;
        logic [brli_pkg::CFG_W-1:0]  nb;
        logic [brli_pkg::CFG_W-1:0]  ns;
        logic [brli_pkg::CFG_W-1:0]  nc;
        int                          commit_pct;
        int                          pool;
        int                          pick;
        int                          ph;
        int                          n;

        foreach (blk_log[i]) blk_log[i] = '0;

        // reset defaults: window 0x1000_0000 .. 0xCFFF_FFFF, 32 slots
        row_chk(brli_pkg::OP_COMMIT, 32'h0000_0000, brli_pkg::ST_DONE, 0, '0);
        row_chk(brli_pkg::OP_WRITE, 32'h0000_0000, brli_pkg::ST_RANGE, 0, '0);
        row_chk(brli_pkg::OP_WRITE, 32'h0FFF_FFFF, brli_pkg::ST_RANGE, 0, '0);
        row_chk(brli_pkg::OP_WRITE, 32'h1000_0000, brli_pkg::ST_APPEND, 0, 20'h00000);
        row_chk(brli_pkg::OP_WRITE, 32'h1000_0FFF, brli_pkg::ST_HIT, 0, 20'h00000);
        row_chk(brli_pkg::OP_WRITE, 32'hCFFF_FFFF, brli_pkg::ST_APPEND, 1, 20'hBFFFF);
        row_chk(brli_pkg::OP_WRITE, 32'hD000_0000, brli_pkg::ST_RANGE, 0, '0);
        row_chk(brli_pkg::OP_WRITE, 32'hFFFF_FFFF, brli_pkg::ST_RANGE, 0, '0);
        row_item(brli_pkg::OP_WRITE, 32'h1000_1000);
        row_item(brli_pkg::OP_WRITE, 32'hCFFF_F000);
        row_item(brli_pkg::OP_COMMIT, 32'h0000_0000);
        row_chk(brli_pkg::OP_COMMIT, 32'hFFFF_FFFF, brli_pkg::ST_DONE, 0, '0);
        // largest 32-bit window (size 0xFFFF_FFFF), end is exclusive; one slot
        row_cfg(brli_pkg::REG_DISK_BASE, 32'h0000_0000);
        row_cfg(brli_pkg::REG_DISK_SIZE, 32'hFFFF_FFFF);
        row_cfg(brli_pkg::REG_LOG_CAP, 32'd1);
        row_chk(brli_pkg::OP_WRITE, 32'hFFFF_FFFF, brli_pkg::ST_RANGE, 0, '0);
        row_chk(brli_pkg::OP_WRITE, 32'hFFFF_E000, brli_pkg::ST_APPEND, 0, 20'hFFFFE);
        row_chk(brli_pkg::OP_WRITE, 32'h0000_0000, brli_pkg::ST_FULL, 0, 20'h00000);
        row_chk(brli_pkg::OP_WRITE, 32'hFFFF_EFFF, brli_pkg::ST_HIT, 0, 20'hFFFFE);
        // zero capacity: hits still found, every miss is full
        row_cfg(brli_pkg::REG_LOG_CAP, 32'd0);
        row_chk(brli_pkg::OP_WRITE, 32'h0000_5000, brli_pkg::ST_FULL, 0, 20'h00005);
        row_item(brli_pkg::OP_COMMIT, 32'h0000_0000);
        row_chk(brli_pkg::OP_WRITE, 32'h1234_5000, brli_pkg::ST_FULL, 0, 20'h12345);
        // window end past 32 bits; capacity above table depth
        row_cfg(brli_pkg::REG_DISK_BASE, 32'hFFFF_FFFF);
        row_cfg(brli_pkg::REG_LOG_CAP, 32'd63);
        row_chk(brli_pkg::OP_WRITE, 32'hFFFF_FFFF, brli_pkg::ST_APPEND, 0, 20'h00000);
        row_chk(brli_pkg::OP_WRITE, 32'hFFFF_FFFE, brli_pkg::ST_RANGE, 0, '0);
        // empty window
        row_cfg(brli_pkg::REG_DISK_SIZE, 32'h0000_0000);
        row_chk(brli_pkg::OP_WRITE, 32'hFFFF_FFFF, brli_pkg::ST_RANGE, 0, '0);
        row_item(brli_pkg::OP_COMMIT, 32'h0000_0000);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        cfg_open = 1'b0;
        foreach (plan[r]) begin
            if (plan[r].is_cfg) begin
                if (!cfg_open)
                    drain(LATENCY_PAD);
                write_reg(plan[r].idx, plan[r].value);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) begin
                    cfg_wr_en <= 1'b0;
                    @(posedge aclk);
                    cfg_open = 1'b0;
                end
                send_item(plan[r].op, plan[r].value, plan[r].typed, plan[r].want);
            end
        end

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin  // defaults, rare commits so the log fills up
                    nb = brli_pkg::DISK_BASE_RST; ns = brli_pkg::DISK_SIZE_RST; nc = 32'd32;
                    commit_pct = 2; pool = 40;
                end
                1: begin
                    nb = 32'h0000_0000; ns = 32'hFFFF_FFFF; nc = 32'd63;
                    commit_pct = 10; pool = 48;
                end
                2: begin
                    nb = 32'hFFFF_0000; ns = 32'hFFFF_FFFF; nc = 32'd5;
                    commit_pct = 12; pool = 16;
                end
                3: begin
                    nb = $urandom; ns = $urandom_range(1, 32'h0003_0000);
                    nc = $urandom_range(0, 8);
                    commit_pct = 12; pool = 12;
                end
                4: begin
                    nb = 32'h2000_0000; ns = 32'h0000_0000; nc = 32'd32;
                    commit_pct = 15; pool = 8;
                end
                default: begin  // 32-block window, capacity one above depth
                    nb = 32'h8000_0000; ns = 32'h0002_0000; nc = 32'd33;
                    commit_pct = 4; pool = 34;
                end
            endcase
            drain(LATENCY_PAD);
            write_reg(brli_pkg::REG_DISK_BASE, nb);
            write_reg(brli_pkg::REG_DISK_SIZE, ns);
            write_reg(brli_pkg::REG_LOG_CAP, nc);
            cfg_wr_en <= 1'b0;
            @(posedge aclk);

            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 1 && n == PHASE_ITEMS / 2)
                    drain(0);
                if ($urandom_range(0, 99) < commit_pct) begin
                    op   = brli_pkg::OP_COMMIT;
                    addr = $urandom;
                end else begin
                    op   = brli_pkg::OP_WRITE;
                    pick = $urandom_range(0, 15);
                    if (pick == 0)
                        addr = $urandom;
                    else if (pick == 1)
                        addr = cfg_base - 1 - $urandom_range(0, 3);
                    else if (pick == 2)
                        addr = cfg_base + cfg_size + $urandom_range(0, 3) - 2;
                    else
                        addr = cfg_base
                               + ($urandom_range(0, pool - 1) << brli_pkg::BLOCK_SHIFT_DEF)
                               + $urandom_range(0, 4095);
                end
                send_item(op, addr, 1'b0, mk(brli_pkg::ST_HIT, 0, '0, 1'b0));
            end
        end

        drain(LATENCY_PAD);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
